// ===== hdl/orl_pkg.sv =====
// Shared types, record codes and result kinds for the object record image loader.
package orl_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int BYTE_BITS     = 8;
    localparam int LEN_BITS      = 16;
    localparam int KIND_BITS     = 2;

    // Record type codes.
    localparam logic [BYTE_BITS-1:0] REC_CONTENT = 8'd6;
    localparam logic [BYTE_BITS-1:0] REC_END     = 8'd4;

    // Fixed header bytes at the start of content and end record payloads.
    localparam logic [LEN_BITS-1:0] CONTENT_HEAD = 16'd3;
    localparam logic [LEN_BITS-1:0] END_HEAD     = 16'd4;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_END     = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CORRUPT = 2'd2;

    // Position of the parser within a record.
    typedef enum logic [3:0] {
        PH_TYPE  = 4'd0,
        PH_LENLO = 4'd1,
        PH_LENHI = 4'd2,
        PH_SKIP  = 4'd3,
        PH_CSUM  = 4'd4,
        PH_SEG   = 4'd5,
        PH_ALO   = 4'd6,
        PH_AHI   = 4'd7,
        PH_DATA  = 4'd8,
        PH_MT    = 4'd9,
        PH_ESEG  = 4'd10,
        PH_OLO   = 4'd11,
        PH_OHI   = 4'd12
    } phase_t;

endpackage

// ===== hdl/object_record_image_loader_core.sv =====
// Top level of the object record image loader: input register, parser and result register.
// A byte accepted into the input register is parsed from there, and its result item, if any,
// is then held in the result register and presented on the master side.
// Throughput: one byte per cycle while the master side takes results; the input register
// and the result register let a new byte be accepted while a finished result still waits.
// Reset (rst_n low, asynchronous) empties both registers, sets the parser to expect a record
// type byte, clears the image high bound and sets the image low bound to "none loaded".
module object_record_image_loader_core
    import orl_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    localparam int RES_BITS  = 3 * ADDR_BITS + 41,
    localparam int DATA_BITS = ((RES_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Stream of object file bytes.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_BITS-1:0] s_axis_tdata,   // in_byte
    // Result items.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // From bit 0 up: write_address, write_data, image_low, image_high, module_type,
    // start_segment, start_offset, then zero fill to a whole byte.
    output logic [DATA_BITS-1:0] m_axis_tdata,
    output logic [KIND_BITS-1:0] m_axis_tuser    // kind
);

    logic                 in_valid;
    logic [BYTE_BITS-1:0] in_byte;
    logic                 out_free;
    logic                 step;
    logic                 res_valid;
    logic [KIND_BITS-1:0] res_kind;
    logic [DATA_BITS-1:0] res_data;

    // A held byte is parsed whenever the result register can take what it produces.
    // Parsing never waits on anything else, so it moves one byte a cycle while that holds.
    assign step = in_valid && out_free;

    orl_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_data   (s_axis_tdata),
        .take     (step),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    // The parser keeps all record state and forms the result item, if any, for each byte.
    // Memory writes carry the address and data, end reports the start address, and
    // every result carries the image bounds as they stand after that byte.
    orl_parse #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res_kind  (res_kind),
        .res_data  (res_data)
    );

    orl_out_reg #(
        .DATA_BITS (DATA_BITS)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res_kind  (res_kind),
        .res_data  (res_data),
        .free      (out_free),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_kind    (m_axis_tuser)
    );

    // With a byte waiting and the result side stalled, no further byte may enter.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the parser was stalled");

endmodule

// ===== hdl/orl_in_reg.sv =====
// Input byte register with ready generation for the loader's slave side.
module orl_in_reg
    import orl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_BITS-1:0] s_data,
    input  logic                 take,
    output logic                 in_valid,
    output logic [BYTE_BITS-1:0] in_byte
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [BYTE_BITS-1:0] byte_reg;

    // The register may refill in the same cycle that its byte is consumed.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            byte_reg <= s_data;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ===== hdl/orl_parse.sv =====
// Record parser: phase state machine, image bounds and result assembly.
module orl_parse
    import orl_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DATA_BITS = ((3 * ADDR_BITS + 41 + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [BYTE_BITS-1:0] in_byte,
    output logic                 res_valid,
    output logic [KIND_BITS-1:0] res_kind,
    output logic [DATA_BITS-1:0] res_data
);

    localparam int LOW_BITS = ADDR_BITS + 1;
    localparam int RES_BITS = 3 * ADDR_BITS + 41;
    localparam int WIDE     = ADDR_BITS + BYTE_BITS;

    phase_t                phase_reg, phase_next;
    logic [BYTE_BITS-1:0]  record_type_reg, record_type_next;
    logic [LEN_BITS-1:0]   remaining_reg, remaining_next;
    logic [ADDR_BITS-1:0]  load_address_reg, load_address_next;
    logic [LOW_BITS-1:0]   low_bound_reg, low_bound_next;
    logic [ADDR_BITS-1:0]  high_bound_reg, high_bound_next;
    logic [BYTE_BITS-1:0]  end_module_type_reg, end_module_type_next;
    logic [BYTE_BITS-1:0]  end_segment_reg, end_segment_next;
    logic [LEN_BITS-1:0]   end_offset_reg, end_offset_next;

    logic [LEN_BITS-1:0]   len;
    logic [LEN_BITS-1:0]   payload;
    logic [LEN_BITS-1:0]   rem_dec;
    logic [WIDE-1:0]       la_wide;
    logic [ADDR_BITS-1:0]  la_hi;
    logic [ADDR_BITS-1:0]  la_inc;

    logic [ADDR_BITS-1:0]  res_addr;
    logic [BYTE_BITS-1:0]  res_byte;
    logic [BYTE_BITS-1:0]  res_mt;
    logic [BYTE_BITS-1:0]  res_seg;
    logic [LEN_BITS-1:0]   res_off;

    // The low length byte waits in the remaining count until the high byte arrives.
    assign len     = {in_byte, remaining_reg[7:0]};
    assign payload = (len != '0) ? len - LEN_BITS'(1) : '0;
    assign rem_dec = (remaining_reg != '0) ? remaining_reg - LEN_BITS'(1) : remaining_reg;
    assign la_wide = WIDE'(load_address_reg) | (WIDE'(in_byte) << 8);
    assign la_hi   = la_wide[ADDR_BITS-1:0];
    assign la_inc  = load_address_reg + ADDR_BITS'(1);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_LENLO: phase_next = PH_LENHI;
                PH_LENHI:
                begin
                    if (record_type_reg == REC_CONTENT)
                    begin
                        if (payload < CONTENT_HEAD)
                        begin
                            phase_next = (payload != '0) ? PH_SKIP : PH_CSUM;
                        end
                        else
                        begin
                            phase_next = PH_SEG;
                        end
                    end
                    else if (record_type_reg == REC_END)
                    begin
                        phase_next = PH_MT;
                    end
                    else
                    begin
                        phase_next = (payload != '0) ? PH_SKIP : PH_CSUM;
                    end
                end
                PH_SKIP:  phase_next = (rem_dec == '0) ? PH_CSUM : PH_SKIP;
                PH_CSUM:  phase_next = PH_TYPE;
                PH_SEG:   phase_next = PH_ALO;
                PH_ALO:   phase_next = PH_AHI;
                PH_AHI:   phase_next = (remaining_reg == '0) ? PH_CSUM : PH_DATA;
                PH_DATA:  phase_next = (rem_dec == '0) ? PH_CSUM : PH_DATA;
                PH_MT:    phase_next = PH_ESEG;
                PH_ESEG:  phase_next = PH_OLO;
                PH_OLO:   phase_next = PH_OHI;
                PH_OHI:   phase_next = (remaining_reg != '0) ? PH_SKIP : PH_CSUM;
                default:  phase_next = PH_LENLO;
            endcase
        end
    end

    // Data registers and the result of the current byte.
    always_comb
    begin
        record_type_next     = record_type_reg;
        remaining_next       = remaining_reg;
        load_address_next    = load_address_reg;
        low_bound_next       = low_bound_reg;
        high_bound_next      = high_bound_reg;
        end_module_type_next = end_module_type_reg;
        end_segment_next     = end_segment_reg;
        end_offset_next      = end_offset_reg;
        res_valid            = 1'b0;
        res_kind             = KIND_WRITE;
        res_addr             = '0;
        res_byte             = '0;
        res_mt               = '0;
        res_seg              = '0;
        res_off              = '0;
        if (step)
        begin
            unique case (phase_reg)
                PH_LENLO: remaining_next = LEN_BITS'(in_byte);
                PH_LENHI:
                begin
                    if (record_type_reg == REC_CONTENT)
                    begin
                        if (payload < CONTENT_HEAD)
                        begin
                            remaining_next = payload;
                            res_valid      = 1'b1;
                            res_kind       = KIND_CORRUPT;
                        end
                        else
                        begin
                            remaining_next = payload - CONTENT_HEAD;
                        end
                    end
                    else if (record_type_reg == REC_END)
                    begin
                        remaining_next = (payload > END_HEAD) ? payload - END_HEAD : '0;
                    end
                    else
                    begin
                        remaining_next = payload;
                    end
                end
                PH_SKIP:  remaining_next = rem_dec;
                PH_CSUM, PH_SEG:
                begin
                end
                PH_ALO:   load_address_next = ADDR_BITS'(in_byte);
                PH_AHI:
                begin
                    load_address_next = la_hi;
                    if ({1'b0, la_hi} < low_bound_reg)
                    begin
                        low_bound_next = {1'b0, la_hi};
                    end
                    if (remaining_reg == '0 && la_hi > high_bound_reg)
                    begin
                        high_bound_next = la_hi;
                    end
                end
                PH_DATA:
                begin
                    load_address_next = la_inc;
                    remaining_next    = rem_dec;
                    if (rem_dec == '0 && la_inc > high_bound_reg)
                    begin
                        high_bound_next = la_inc;
                    end
                    res_valid = 1'b1;
                    res_kind  = KIND_WRITE;
                    res_addr  = load_address_reg;
                    res_byte  = in_byte;
                end
                PH_MT:    end_module_type_next = in_byte;
                PH_ESEG:  end_segment_next = in_byte;
                PH_OLO:   end_offset_next = LEN_BITS'(in_byte);
                PH_OHI:
                begin
                    end_offset_next = {in_byte, end_offset_reg[7:0]};
                    res_valid       = 1'b1;
                    res_kind        = KIND_END;
                    res_mt          = end_module_type_reg;
                    res_seg         = end_segment_reg;
                    res_off         = {in_byte, end_offset_reg[7:0]};
                end
                default:  record_type_next = in_byte;
            endcase
        end
    end

    // Bounds are reported as they stand after this byte.
    always_comb
    begin
        res_data = '0;
        res_data[RES_BITS-1:0] = {res_off, res_seg, res_mt, high_bound_next,
                                  low_bound_next, res_byte, res_addr};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_TYPE;
            record_type_reg     <= '0;
            remaining_reg       <= '0;
            load_address_reg    <= '0;
            low_bound_reg       <= LOW_BITS'(1) << ADDR_BITS;
            high_bound_reg      <= '0;
            end_module_type_reg <= '0;
            end_segment_reg     <= '0;
            end_offset_reg      <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            record_type_reg     <= record_type_next;
            remaining_reg       <= remaining_next;
            load_address_reg    <= load_address_next;
            low_bound_reg       <= low_bound_next;
            high_bound_reg      <= high_bound_next;
            end_module_type_reg <= end_module_type_next;
            end_segment_reg     <= end_segment_next;
            end_offset_reg      <= end_offset_next;
        end
    end

    // The image bounds only ever widen.
    a_low_never_rises: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> low_bound_reg <= $past(low_bound_reg))
        else $error("image low bound rose");

    a_high_never_falls: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> high_bound_reg >= $past(high_bound_reg))
        else $error("image high bound fell");

    a_data_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_DATA && remaining_reg != '0)
        |=> remaining_reg == $past(remaining_reg) - LEN_BITS'(1))
        else $error("data byte count did not step down by one");

endmodule

// ===== hdl/orl_out_reg.sv =====
// Result register holding one result item for the master side.
module orl_out_reg
    import orl_pkg::*;
#(
    parameter int DATA_BITS = ((3 * ADDR_BITS_DEF + 41 + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 res_valid,
    input  logic [KIND_BITS-1:0] res_kind,
    input  logic [DATA_BITS-1:0] res_data,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_BITS-1:0] m_data,
    output logic [KIND_BITS-1:0] m_kind
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [DATA_BITS-1:0] data_reg;
    logic [KIND_BITS-1:0] kind_reg;

    // Free when empty or when the held item leaves at this edge.
    assign free       = !valid_reg || m_ready;
    assign valid_next = free ? (step && res_valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && step && res_valid)
        begin
            data_reg <= res_data;
            kind_reg <= res_kind;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
    assign m_kind  = kind_reg;

endmodule
